[hw/rtl/touch_event_generator_core_defines.svh]
// Assertion macros shared by the touch event generator RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef TOUCH_EVENT_GENERATOR_CORE_DEFINES_SVH
`define TOUCH_EVENT_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define TEG_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TEG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/teg_pkg.sv]
// Types, event codes and record table for the touch event generator.
// No dependencies; used by teg_div and touch_event_generator_core.
package teg_pkg;

    localparam int VALUE_BITS = 13;

    localparam logic [1:0] EV_SYN = 2'd0;
    localparam logic [1:0] EV_KEY = 2'd1;
    localparam logic [1:0] EV_ABS = 2'd3;

    localparam logic [8:0] CODE_SYN_REPORT = 9'd0;
    localparam logic [8:0] CODE_ABS_X      = 9'd0;
    localparam logic [8:0] CODE_ABS_Y      = 9'd1;
    localparam logic [8:0] CODE_TOOL_FINGER = 9'd325;
    localparam logic [8:0] CODE_TOUCH      = 9'd330;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef enum logic [1:0] {
        KIND_NOOP,
        KIND_RELEASE,
        KIND_PRESS_NEW,
        KIND_PRESS_MOVE
    } teg_kind_t;

    typedef struct packed {
        logic busy;
        logic done;
    } teg_div_status_t;

    typedef struct packed {
        logic [1:0]            ev_type;
        logic [8:0]            code;
        logic [VALUE_BITS-1:0] value;
        logic                  last;
        logic                  no_op;
    } teg_record_t;

    function automatic teg_record_t teg_record(
        input teg_kind_t             kind,
        input logic [2:0]            idx,
        input logic [VALUE_BITS-1:0] sx,
        input logic [VALUE_BITS-1:0] sy
    );
        teg_record_t r;
        logic [2:0]  j;
        r = '{default: '0};
        j = idx;
        case (kind)
            KIND_NOOP:
            begin
                r.ev_type = EV_SYN;
                r.code    = CODE_SYN_REPORT;
                r.last    = 1'b1;
                r.no_op   = 1'b1;
            end
            KIND_RELEASE:
            begin
                case (idx)
                    3'd0:
                    begin
                        r.ev_type = EV_KEY;
                        r.code    = CODE_TOUCH;
                    end
                    3'd1:
                    begin
                        r.ev_type = EV_KEY;
                        r.code    = CODE_TOOL_FINGER;
                    end
                    default:
                    begin
                        r.ev_type = EV_SYN;
                        r.code    = CODE_SYN_REPORT;
                        r.last    = 1'b1;
                    end
                endcase
            end
            default:
            begin
                if (kind == KIND_PRESS_NEW && idx < 3'd2)
                begin
                    r.ev_type = EV_KEY;
                    r.code    = (idx == 3'd0) ? CODE_TOUCH : CODE_TOOL_FINGER;
                    r.value   = VALUE_BITS'(1);
                end
                else
                begin
                    if (kind == KIND_PRESS_NEW)
                    begin
                        j = idx - 3'd2;
                    end
                    case (j)
                        3'd0:
                        begin
                            r.ev_type = EV_ABS;
                            r.code    = CODE_ABS_X;
                            r.value   = sx;
                        end
                        3'd1:
                        begin
                            r.ev_type = EV_ABS;
                            r.code    = CODE_ABS_Y;
                            r.value   = sy;
                        end
                        default:
                        begin
                            r.ev_type = EV_SYN;
                            r.code    = CODE_SYN_REPORT;
                            r.last    = 1'b1;
                        end
                    endcase
                end
            end
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/teg_div.sv]
// Shared radix-2 restoring divider that scales one axis coordinate.
// Uses teg_pkg for the status struct; instantiated by touch_event_generator_core.
module teg_div #(
    parameter int COORD_BITS   = 12,
    parameter int OUTPUT_SCALE = 4096
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [COORD_BITS:0]              coord,
    input  logic [COORD_BITS-1:0]                   dim,
    output teg_pkg::teg_div_status_t                status,
    output logic [$clog2(OUTPUT_SCALE+1)-1:0]       quotient
);

    localparam int QB = $clog2(OUTPUT_SCALE + 1);
    localparam int NB = COORD_BITS + QB + 2;
    localparam int CW = $clog2(QB + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [COORD_BITS:0]   rem_reg;
    logic [QB-1:0]         quo_reg;

    logic [NB-1:0]         num;
    logic [COORD_BITS:0]   div2;
    logic [COORD_BITS+1:0] shifted;
    logic                  fits;
    logic                  is_neg;
    logic                  is_sat;

    assign div2    = {dim, 1'b0};
    assign num     = NB'({coord[COORD_BITS-1:0], 1'b0}) * NB'(OUTPUT_SCALE) + NB'(dim);
    assign is_neg  = coord[COORD_BITS];
    assign is_sat  = !is_neg && (coord[COORD_BITS-1:0] >= dim);
    assign shifted = {rem_reg, quo_reg[QB-1]};
    assign fits    = shifted >= {1'b0, div2};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (is_neg || is_sat)
                begin
                    quo_reg  <= is_neg ? '0 : QB'(OUTPUT_SCALE);
                    done_reg <= 1'b1;
                end
                else
                begin
                    rem_reg  <= num[QB+COORD_BITS:QB];
                    quo_reg  <= num[QB-1:0];
                    cnt_reg  <= CW'(QB);
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? (COORD_BITS+1)'(shifted - {1'b0, div2})
                                : shifted[COORD_BITS:0];
                quo_reg <= {quo_reg[QB-2:0], fits};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

[hw/rtl/touch_event_generator_core.sv]
// Touch event generator: a press runs the two axis divisions, x then y, on the one shared
// restoring divider (Q = $clog2(OUTPUT_SCALE+1) quotient bits, 13 at the default scale, one
// quotient bit per cycle; an axis that clamps to zero or saturates skips the iterations),
// then loads its records while the output side takes words; a release skips the divider
// and loads its records directly.
// The block takes no new report until the last record is loaded.
// Depends on teg_pkg, teg_div and touch_event_generator_core_defines.svh.
module touch_event_generator_core #(
    parameter int COORD_BITS   = 12,
    parameter int OUTPUT_SCALE = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   rotation_we,
    input  logic [1:0]                             rotation_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // x, y, frame_width, frame_height
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    // command
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // event_type, event_code, event_value
    output logic [23:0]                            m_tdata,
    // no_op
    output logic                                   m_tuser,
    output logic                                   m_tlast
);

    localparam int CB = COORD_BITS;
    localparam int QB = $clog2(OUTPUT_SCALE + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t                          state_reg;
    logic                            touch_active_reg;
    logic [1:0]                      rotation_reg;
    logic                            div_start_reg;
    logic                            axis_y_reg;
    logic [2:0]                      idx_reg;
    teg_pkg::teg_kind_t              kind_reg;
    logic signed [CB:0]              tx_reg;
    logic signed [CB:0]              ty_reg;
    logic [CB-1:0]                   dx_reg;
    logic [CB-1:0]                   dy_reg;
    logic [teg_pkg::VALUE_BITS-1:0]  sx_reg;
    logic [teg_pkg::VALUE_BITS-1:0]  sy_reg;
    logic                            m_tvalid_reg;
    logic [23:0]                     m_tdata_reg;
    logic                            m_tuser_reg;
    logic                            m_tlast_reg;

    logic [CB-1:0]                   in_x;
    logic [CB-1:0]                   in_y;
    logic [CB-1:0]                   in_fw;
    logic [CB-1:0]                   in_fh;
    logic [CB-1:0]                   dim_w;
    logic [CB-1:0]                   dim_h;
    logic signed [CB:0]              tx_next;
    logic signed [CB:0]              ty_next;
    logic                            in_accept;
    logic                            out_load;
    teg_pkg::teg_div_status_t        div_status;
    logic [QB-1:0]                   div_q;
    teg_pkg::teg_record_t            rec;

    assign in_x  = s_tdata[CB-1:0];
    assign in_y  = s_tdata[2*CB-1:CB];
    assign in_fw = s_tdata[3*CB-1:2*CB];
    assign in_fh = s_tdata[4*CB-1:3*CB];

    assign dim_w = rotation_reg[0] ? in_fh : in_fw;
    assign dim_h = rotation_reg[0] ? in_fw : in_fh;

    always_comb
    begin
        case (rotation_reg)
            teg_pkg::ROT_90:
            begin
                tx_next = $signed({1'b0, dim_w}) - $signed({1'b0, in_y});
                ty_next = $signed({1'b0, in_x});
            end
            teg_pkg::ROT_180:
            begin
                tx_next = $signed({1'b0, dim_w}) - $signed({1'b0, in_x});
                ty_next = $signed({1'b0, dim_h}) - $signed({1'b0, in_y});
            end
            teg_pkg::ROT_270:
            begin
                tx_next = $signed({1'b0, in_y});
                ty_next = $signed({1'b0, dim_h}) - $signed({1'b0, in_x});
            end
            default:
            begin
                tx_next = $signed({1'b0, in_x});
                ty_next = $signed({1'b0, in_y});
            end
        endcase
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign rec       = teg_pkg::teg_record(kind_reg, idx_reg, sx_reg, sy_reg);

    teg_div #(
        .COORD_BITS   (COORD_BITS),
        .OUTPUT_SCALE (OUTPUT_SCALE)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .coord    (axis_y_reg ? ty_reg : tx_reg),
        .dim      (axis_y_reg ? dy_reg : dx_reg),
        .status   (div_status),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            touch_active_reg <= 1'b0;
            rotation_reg     <= teg_pkg::ROT_0;
            div_start_reg    <= 1'b0;
            axis_y_reg       <= 1'b0;
            idx_reg          <= '0;
            kind_reg         <= teg_pkg::KIND_NOOP;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (rotation_we)
            begin
                rotation_reg <= rotation_wdata;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        idx_reg <= '0;
                        if (s_tuser)
                        begin
                            kind_reg         <= touch_active_reg ? teg_pkg::KIND_PRESS_MOVE
                                                                 : teg_pkg::KIND_PRESS_NEW;
                            touch_active_reg <= 1'b1;
                            tx_reg           <= tx_next;
                            ty_reg           <= ty_next;
                            dx_reg           <= (dim_w == '0) ? CB'(1) : dim_w;
                            dy_reg           <= (dim_h == '0) ? CB'(1) : dim_h;
                            axis_y_reg       <= 1'b0;
                            div_start_reg    <= 1'b1;
                            state_reg        <= ST_DIV;
                        end
                        else
                        begin
                            kind_reg         <= touch_active_reg ? teg_pkg::KIND_RELEASE
                                                                 : teg_pkg::KIND_NOOP;
                            touch_active_reg <= 1'b0;
                            state_reg        <= ST_EMIT;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_status.done)
                    begin
                        if (!axis_y_reg)
                        begin
                            sx_reg        <= teg_pkg::VALUE_BITS'(div_q);
                            axis_y_reg    <= 1'b1;
                            div_start_reg <= 1'b1;
                        end
                        else
                        begin
                            sy_reg    <= teg_pkg::VALUE_BITS'(div_q);
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        m_tdata_reg  <= {rec.value, rec.code, rec.ev_type};
                        m_tuser_reg  <= rec.no_op;
                        m_tlast_reg  <= rec.last;
                        if (rec.last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`include "touch_event_generator_core_defines.svh"

    `TEG_ASSERT(a_ready_div_idle, s_tready, !div_status.busy && !div_status.done, "divider active while ready")
    `TEG_ASSERT(a_noop_is_last, m_tvalid && m_tuser, m_tlast, "no-op word without last")
    `TEG_ASSERT_NEXT(a_release_clears, in_accept && !s_tuser, !touch_active_reg, "release left touch active")
    `TEG_ASSERT(a_done_in_div, div_status.done, state_reg == ST_DIV, "divider result outside division")

endmodule
